FILE: src/ppfa_pkg.sv
// Shared constants, types and helpers for the physical page frame allocator.
// Used by physical_page_frame_allocator, page_alloc_checker and the testbench; depends on nothing else.
`default_nettype none

package ppfa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int STAT_W     = 2;
  localparam int PG_W       = $clog2(NUM_PAGES);
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int GRP_W      = 8;
  localparam int NUM_GRP    = WORD_W / GRP_W;
  localparam int GSEL_W     = $clog2(NUM_GRP);
  localparam int GBIT_W     = $clog2(GRP_W);
  localparam int NUM_WORDS  = NUM_PAGES / WORD_W;
  localparam int WADDR_W    = PG_W - BIT_W;
  localparam int IDX_W      = ADDR_W - PAGE_SHIFT;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTALLOC = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } find_t;

  // Lowest set bit of a word, found in two levels of eight.
  function automatic find_t find_first(input word_t v);
    find_t                res;
    logic [NUM_GRP-1:0]   grp_any;
    logic [GSEL_W-1:0]    gsel;
    logic [GRP_W-1:0]     grp;
    logic [GBIT_W-1:0]    bsel;
    gsel = '0;
    bsel = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any[g] = |v[g*GRP_W +: GRP_W];
    end
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = GSEL_W'(g);
      end
    end
    grp = v[gsel*GRP_W +: GRP_W];
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (grp[b]) begin
        bsel = GBIT_W'(b);
      end
    end
    res.found = |grp_any;
    res.pos   = {gsel, bsel};
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/physical_page_frame_allocator.sv
// Physical page frame allocator: first-fit allocate and checked free over a
// packed in-use flag memory. Depends on ppfa_pkg.
// Allocate: S_SCAN checks W flag words in turn, W = flag words scanned (1..64).
// Free: S_FCHK checks one flag word; a rejected address or an empty range skips it.
// One item at a time; the scan reads one 64-flag word per cycle from the memory.
// Reset clears all flags at once through per-word valid bits; no clearing pass.
`default_nettype none

module physical_page_frame_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [ppfa_pkg::ADDR_W-1:0]   in_page_addr,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ppfa_pkg::STAT_W-1:0]        out_status,
  output logic [ppfa_pkg::ADDR_W-1:0]        out_granted_addr,
  output logic [ppfa_pkg::CFG_W-1:0]         out_free_count,
  input  wire logic                          cfg_we,
  input  wire logic [ppfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppfa_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FCHK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [ppfa_pkg::CFG_W-1:0]       first_page_r, page_count_r;
  logic [ppfa_pkg::CFG_W-1:0]       alloc_cnt_r, alloc_cnt_nxt;
  logic [ppfa_pkg::WADDR_W-1:0]     cur_word_r, cur_word_nxt;
  logic [ppfa_pkg::WADDR_W-1:0]     fw_r, fw_nxt, lw_r, lw_nxt;
  ppfa_pkg::word_t                  lo_mask_r, lo_mask_nxt, hi_mask_r, hi_mask_nxt;
  logic [ppfa_pkg::BIT_W-1:0]       bit_r, bit_nxt;
  logic [ppfa_pkg::STAT_W-1:0]      status_r, status_nxt;
  logic [ppfa_pkg::ADDR_W-1:0]      granted_r, granted_nxt;
  logic                             out_valid_r;
  logic [ppfa_pkg::STAT_W-1:0]      out_status_r;
  logic [ppfa_pkg::ADDR_W-1:0]      out_granted_r;
  logic [ppfa_pkg::CFG_W-1:0]       out_free_r;

  ppfa_pkg::word_t                  mem [ppfa_pkg::NUM_WORDS];
  logic [ppfa_pkg::NUM_WORDS-1:0]   row_vld_r;
  ppfa_pkg::word_t                  rd_data_r;
  logic                             rd_vld_r;
  logic [ppfa_pkg::WADDR_W-1:0]     rd_addr, wr_addr;
  ppfa_pkg::word_t                  wr_data, word, avail;
  logic                             wr_en;

  logic [ppfa_pkg::CFG_W-1:0]       lim, lm, span, free_now;
  logic                             empty, bad_addr, accept;
  logic [ppfa_pkg::IDX_W-1:0]       idx;
  ppfa_pkg::find_t                  hit;

  assign lim   = (page_count_r > ppfa_pkg::CFG_W'(ppfa_pkg::NUM_PAGES)) ?
                 ppfa_pkg::CFG_W'(ppfa_pkg::NUM_PAGES) : page_count_r;
  assign lm    = lim - 1'b1;
  assign empty = (first_page_r >= lim);
  assign span  = lim - first_page_r;
  assign free_now = (empty || span <= alloc_cnt_r) ? '0 : span - alloc_cnt_r;

  assign idx      = in_page_addr[ppfa_pkg::ADDR_W-1:ppfa_pkg::PAGE_SHIFT];
  assign bad_addr = (in_page_addr[ppfa_pkg::PAGE_SHIFT-1:0] != '0) ||
                    (idx < ppfa_pkg::IDX_W'(first_page_r)) ||
                    (idx >= ppfa_pkg::IDX_W'(lim));

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign word  = rd_vld_r ? rd_data_r : '0;
  assign avail = ~word & ((cur_word_r == fw_r) ? lo_mask_r : '1)
                       & ((cur_word_r == lw_r) ? hi_mask_r : '1);
  assign hit   = ppfa_pkg::find_first(avail);

  always_comb begin
    state_nxt     = state_r;
    alloc_cnt_nxt = alloc_cnt_r;
    cur_word_nxt  = cur_word_r;
    fw_nxt        = fw_r;
    lw_nxt        = lw_r;
    lo_mask_nxt   = lo_mask_r;
    hi_mask_nxt   = hi_mask_r;
    bit_nxt       = bit_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    rd_addr       = cur_word_r + 1'b1;
    wr_en         = 1'b0;
    wr_addr       = cur_word_r;
    wr_data       = word;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          granted_nxt = '0;
          if (!in_func) begin
            if (empty) begin
              status_nxt = ppfa_pkg::STAT_OOM;
              state_nxt  = S_FIN;
            end else begin
              rd_addr      = first_page_r[ppfa_pkg::PG_W-1:ppfa_pkg::BIT_W];
              cur_word_nxt = rd_addr;
              fw_nxt       = rd_addr;
              lw_nxt       = lm[ppfa_pkg::PG_W-1:ppfa_pkg::BIT_W];
              lo_mask_nxt  = {ppfa_pkg::WORD_W{1'b1}} << first_page_r[ppfa_pkg::BIT_W-1:0];
              hi_mask_nxt  = {ppfa_pkg::WORD_W{1'b1}} >> (~lm[ppfa_pkg::BIT_W-1:0]);
              state_nxt    = S_SCAN;
            end
          end else if (bad_addr) begin
            status_nxt = ppfa_pkg::STAT_RANGE;
            state_nxt  = S_FIN;
          end else begin
            rd_addr      = idx[ppfa_pkg::PG_W-1:ppfa_pkg::BIT_W];
            cur_word_nxt = rd_addr;
            bit_nxt      = idx[ppfa_pkg::BIT_W-1:0];
            state_nxt    = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (hit.found) begin
          wr_en         = 1'b1;
          wr_data       = word | (ppfa_pkg::word_t'(1) << hit.pos);
          alloc_cnt_nxt = alloc_cnt_r + 1'b1;
          status_nxt    = ppfa_pkg::STAT_OK;
          granted_nxt   = ppfa_pkg::ADDR_W'({cur_word_r, hit.pos}) << ppfa_pkg::PAGE_SHIFT;
          state_nxt     = S_FIN;
        end else if (cur_word_r == lw_r) begin
          status_nxt = ppfa_pkg::STAT_OOM;
          state_nxt  = S_FIN;
        end else begin
          cur_word_nxt = cur_word_r + 1'b1;
        end
      end
      S_FCHK: begin
        if (word[bit_r]) begin
          wr_en         = 1'b1;
          wr_data       = word & ~(ppfa_pkg::word_t'(1) << bit_r);
          alloc_cnt_nxt = alloc_cnt_r - 1'b1;
          status_nxt    = ppfa_pkg::STAT_OK;
        end else begin
          status_nxt = ppfa_pkg::STAT_NOTALLOC;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_cnt_r  <= '0;
      first_page_r <= '0;
      page_count_r <= ppfa_pkg::CFG_W'(ppfa_pkg::NUM_PAGES);
      row_vld_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      rd_vld_r    <= row_vld_r[rd_addr];
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ppfa_pkg::REG_FIRST_PAGE: first_page_r <= cfg_data;
          ppfa_pkg::REG_PAGE_COUNT: page_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_word_r <= cur_word_nxt;
    fw_r       <= fw_nxt;
    lw_r       <= lw_nxt;
    lo_mask_r  <= lo_mask_nxt;
    hi_mask_r  <= hi_mask_nxt;
    bit_r      <= bit_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_status_r  <= status_r;
      out_granted_r <= granted_r;
      out_free_r    <= free_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_granted_r;
  assign out_free_count   = out_free_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= ppfa_pkg::CFG_W'(ppfa_pkg::NUM_PAGES))
    else $error("allocated page count exceeds the number of pages");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ppfa_pkg::STAT_OK |-> out_granted_addr == '0)
    else $error("failed item carries a granted address");

  a_scan_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && state_r == S_SCAN |-> $countones(wr_data) == $countones(word) + 1)
    else $error("allocation write does not set exactly one flag");

  a_free_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && state_r == S_FCHK |-> $countones(wr_data) + 1 == $countones(word))
    else $error("free write does not clear exactly one flag");

endmodule

`default_nettype wire

FILE: dv/page_alloc_tb_pkg.sv
// Operation codes of the allocator's input item, shared by the testbench
// top and the checker. Depends on nothing else.
package page_alloc_tb_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

FILE: dv/page_alloc_checker.sv
// Checker for the page frame allocator: mirrors the in-use flags and the registers,
// predicts every reply and compares it with what the block returns.
// Depends on ppfa_pkg and page_alloc_tb_pkg.
module page_alloc_checker
  import ppfa_pkg::*;
  import page_alloc_tb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 in_func,
  input  wire logic [ADDR_W-1:0]    in_page_addr,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [STAT_W-1:0]    out_status,
  input  wire logic [ADDR_W-1:0]    out_granted_addr,
  input  wire logic [CFG_W-1:0]     out_free_count,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int unsigned FREE_CNT_MAX = 2 ** CFG_W - 1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted;
    logic [CFG_W-1:0]  free_cnt;
  } page_reply_t;

  logic          in_use [NUM_PAGES];
  int unsigned   held_pages;
  logic [CFG_W-1:0] first_pg;
  logic [CFG_W-1:0] pg_count;
  page_reply_t   replies_due[$];

  function automatic int unsigned page_limit();
    return (pg_count > NUM_PAGES) ? NUM_PAGES : pg_count;
  endfunction

  // The count follows the held pages, not a recount of the current window.
  function automatic logic [CFG_W-1:0] window_free();
    int unsigned lim, span, f;
    lim = page_limit();
    if (first_pg >= lim) return '0;
    span = lim - first_pg;
    f = (span > held_pages) ? span - held_pages : 0;
    if (f > FREE_CNT_MAX) f = FREE_CNT_MAX;
    return CFG_W'(f);
  endfunction

  function automatic page_reply_t apply_page_op(input logic op, input logic [ADDR_W-1:0] addr);
    page_reply_t r;
    int unsigned lim, pg;
    logic        done;
    lim = page_limit();
    done = 1'b0;
    r.status = STAT_OK;
    r.granted = '0;
    if (op == OP_ALLOC) begin
      r.status = STAT_OOM;
      for (int unsigned i = first_pg; i < lim; i++) begin
        if (!done && !in_use[i]) begin
          in_use[i] = 1'b1;
          held_pages++;
          r.granted = ADDR_W'(i << PAGE_SHIFT);
          r.status = STAT_OK;
          done = 1'b1;
        end
      end
    end else begin
      pg = addr >> PAGE_SHIFT;
      if (addr[PAGE_SHIFT-1:0] != '0 || pg < first_pg || pg >= lim) begin
        r.status = STAT_RANGE;
      end else if (!in_use[pg]) begin
        r.status = STAT_NOTALLOC;
      end else begin
        in_use[pg] = 1'b0;
        if (held_pages > 0) held_pages--;
      end
    end
    r.free_cnt = window_free();
    return r;
  endfunction

  always @(posedge clk) begin
    page_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAGES; i++) in_use[i] = 1'b0;
      held_pages = 0;
      first_pg = '0;
      pg_count = CFG_W'(NUM_PAGES);
      replies_due.delete();
      outstanding = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_PAGE: first_pg = cfg_data;
          REG_PAGE_COUNT: pg_count = cfg_data;
          default: ;
        endcase
      end
      // The reply leaving now belongs to an older item, so compare before predicting.
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: status %0d granted %h free %0d",
                     out_status, out_granted_addr, out_free_count);
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status || out_granted_addr !== want.granted ||
              out_free_count !== want.free_cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: status %0d/%0d granted %h/%h free %0d/%0d (exp/got)",
                       want.status, out_status, want.granted, out_granted_addr,
                       want.free_cnt, out_free_count);
          end
        end
      end
      if (in_valid && in_ready) replies_due.push_back(apply_page_op(in_func, in_page_addr));
      outstanding = replies_due.size();
    end
  end

endmodule

FILE: dv/physical_page_frame_allocator_tb.sv
// Stimulus and verdict for physical_page_frame_allocator: directed corner cases,
// then random windows of allocate and free requests under varying back-pressure.
// Depends on ppfa_pkg, page_alloc_tb_pkg and page_alloc_checker.
module physical_page_frame_allocator_tb;
  import ppfa_pkg::*;
  import page_alloc_tb_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_func = OP_ALLOC;
  logic [ADDR_W-1:0]    in_page_addr = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_PAGE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [ADDR_W-1:0]    out_granted_addr;
  logic [CFG_W-1:0]     out_free_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  always #2 clk = ~clk;

  physical_page_frame_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_page_addr(in_page_addr),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_granted_addr(out_granted_addr), .out_free_count(out_free_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  page_alloc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_page_addr(in_page_addr),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_granted_addr(out_granted_addr), .out_free_count(out_free_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_page_addr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input int unsigned first_idx, input int unsigned count_val);
    drain_replies();
    write_reg(REG_FIRST_PAGE, first_idx);
    write_reg(REG_PAGE_COUNT, count_val);
  endtask

  initial begin
    int                unsent;
    int                burst;
    int unsigned       first_idx, count_val, lo, hi, pg, pick;
    logic [ADDR_W-1:0] addr;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 55;

    // Reset window: freeing an unused page, first fit, alignment and range checks.
    send_req(OP_FREE, 32'h0000_0000);
    send_req(OP_ALLOC, 32'h0000_0000);
    send_req(OP_ALLOC, 32'hffff_ffff);
    send_req(OP_FREE, 32'h0000_1001);
    send_req(OP_FREE, 32'h0000_1000);
    send_req(OP_FREE, 32'h0000_1000);
    send_req(OP_ALLOC, 32'h1234_5678);
    send_req(OP_FREE, 32'hffff_f000);
    send_req(OP_FREE, 32'hffff_ffff);
    send_req(OP_FREE, 32'h00ff_f000);
    // Top two pages only, with the page count clamped to the store size.
    set_window(4094, 8191);
    send_req(OP_ALLOC, 32'h0000_0000);
    send_req(OP_ALLOC, 32'h0000_0000);
    send_req(OP_ALLOC, 32'hffff_ffff);
    send_req(OP_FREE, 32'h00ff_d000);
    send_req(OP_FREE, 32'h0100_0000);
    send_req(OP_FREE, 32'h00ff_f000);
    // Empty windows.
    set_window(4096, 4096);
    send_req(OP_ALLOC, 32'h0000_0000);
    send_req(OP_FREE, 32'h00ff_e000);
    set_window(8191, 0);
    send_req(OP_ALLOC, 32'h0000_0000);
    send_req(OP_FREE, 32'h0000_0000);
    set_window(0, 0);
    send_req(OP_ALLOC, 32'h0000_0000);
    // A window that straddles a flag word boundary.
    set_window(60, 70);
    repeat (3) send_req(OP_ALLOC, $urandom());

    unsent = RANDOM_ITEMS;
    while (unsent > 0) begin
      if (unsent > 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 55;
      end else if (unsent > RANDOM_ITEMS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: begin
          first_idx = 0;
          count_val = NUM_PAGES;
        end
        1: begin
          first_idx = $urandom_range(NUM_PAGES - 1);
          count_val = $urandom_range(first_idx);
        end
        2: begin
          first_idx = $urandom_range(8191, NUM_PAGES);
          count_val = $urandom_range(8191);
        end
        3: begin
          first_idx = $urandom_range(NUM_PAGES - 1, NUM_PAGES - 96);
          count_val = $urandom_range(8191, NUM_PAGES + 1);
        end
        default: begin
          first_idx = $urandom_range(NUM_PAGES - 1);
          count_val = first_idx + $urandom_range(160, 1);
        end
      endcase
      set_window(first_idx, count_val);
      lo = first_idx;
      hi = (count_val > NUM_PAGES) ? NUM_PAGES : count_val;
      burst = $urandom_range(120, 40);
      while (burst > 0 && unsent > 0) begin
        pick = $urandom_range(99);
        addr = $urandom();
        if (pick < 55) begin
          send_req(OP_ALLOC, addr);
        end else if (pick < 85) begin
          pg = (hi > lo) ? $urandom_range(hi - 1, lo) : $urandom_range(NUM_PAGES - 1);
          send_req(OP_FREE, ADDR_W'(pg << PAGE_SHIFT));
        end else if (pick < 90) begin
          send_req(OP_FREE, addr);
        end else if (pick < 95) begin
          if (addr[PAGE_SHIFT-1:0] == '0) addr[0] = 1'b1;
          send_req(OP_FREE, addr);
        end else begin
          pg = $urandom_range(1) ? hi : lo - 1;
          send_req(OP_FREE, ADDR_W'(pg << PAGE_SHIFT));
        end
        burst--;
        unsent--;
        if ($urandom_range(49) == 0) drain_replies();
      end
    end

    drain_replies();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
